### design/psc_pkg.sv
`timescale 1ns / 1ps
package psc_pkg;

  localparam int LIMIT_W = 17;
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_FILL   = 4'd1;
  localparam step_t STEP_SINIT  = 4'd2;
  localparam step_t STEP_SCHK   = 4'd3;
  localparam step_t STEP_SWAIT  = 4'd4;
  localparam step_t STEP_STRIKE = 4'd5;
  localparam step_t STEP_SNEXT  = 4'd6;
  localparam step_t STEP_CINIT  = 4'd7;
  localparam step_t STEP_CREAD  = 4'd8;
  localparam step_t STEP_EMIT   = 4'd9;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_K_GE_N,
    COND_SQ_GE_N,
    COND_COMPOSITE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_FILL,
    ACT_SINIT,
    ACT_SREAD,
    ACT_SLOAD,
    ACT_STRIKE,
    ACT_SNEXT,
    ACT_CINIT,
    ACT_CREAD,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    cond_t cond;
    act_t  act;
    logic  on_true;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic fill;
    logic sinit;
    logic sread;
    logic sload;
    logic strike;
    logic snext;
    logic cinit;
    logic cread;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic k_ge_n;
    logic sq_ge_n;
    logic composite;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      STEP_IDLE:   w = '{COND_IN_VALID,  ACT_LOAD,   1'b1, STEP_FILL,   STEP_IDLE};
      STEP_FILL:   w = '{COND_K_GE_N,    ACT_FILL,   1'b0, STEP_SINIT,  STEP_FILL};
      STEP_SINIT:  w = '{COND_ALWAYS,    ACT_SINIT,  1'b1, STEP_SCHK,   STEP_SCHK};
      STEP_SCHK:   w = '{COND_SQ_GE_N,   ACT_SREAD,  1'b0, STEP_CINIT,  STEP_SWAIT};
      STEP_SWAIT:  w = '{COND_COMPOSITE, ACT_SLOAD,  1'b0, STEP_SNEXT,  STEP_STRIKE};
      STEP_STRIKE: w = '{COND_K_GE_N,    ACT_STRIKE, 1'b0, STEP_SNEXT,  STEP_STRIKE};
      STEP_SNEXT:  w = '{COND_ALWAYS,    ACT_SNEXT,  1'b1, STEP_SCHK,   STEP_SCHK};
      STEP_CINIT:  w = '{COND_ALWAYS,    ACT_CINIT,  1'b1, STEP_CREAD,  STEP_CREAD};
      STEP_CREAD:  w = '{COND_K_GE_N,    ACT_CREAD,  1'b0, STEP_EMIT,   STEP_CREAD};
      STEP_EMIT:   w = '{COND_OUT_FREE,  ACT_EMIT,   1'b1, STEP_IDLE,   STEP_EMIT};
      default:     w = '{COND_ALWAYS,    ACT_SINIT,  1'b0, STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### design/psc_if.sv
`timescale 1ns / 1ps
interface psc_in_if;
  import psc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] limit;
  modport source (output valid, output limit, input ready);
  modport sink (input valid, input limit, output ready);
endinterface

interface psc_out_if;
  import psc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_count;
  modport source (output valid, output prime_count, input ready);
  modport sink (input valid, input prime_count, output ready);
endinterface

### design/prime_sieve_counter_top.sv
`timescale 1ns / 1ps
// channel   dir  payload            handshake
// in_req    in   limit[16:0]        valid/ready
// out_res   out  prime_count[12:0]  valid/ready
//
// the pace of a run over n = min(limit, MAX_BOUND) is set by the single write/read port
// of the bitmap: one entry per cycle in the fill, strike and count sweeps
// synchronous active-low reset returns the sequencer to idle; bitmap is not cleared
// a new request is taken only when idle, while a finished count may still wait on out_res
// the run stalls at its last step until the output register is free
module prime_sieve_counter_top #(
  parameter int MAX_BOUND = 65536
) (
  input logic      clk,
  input logic      rst_n,
  psc_in_if.sink   in_req,
  psc_out_if.source out_res
);
  import psc_pkg::*;

  localparam int AW = $clog2(MAX_BOUND);
  localparam int NW = $clog2(MAX_BOUND + 1);
  localparam int WW = NW + 1;
  localparam int CW = (NW > LIMIT_W) ? NW : LIMIT_W;
  localparam int MW = (WW > COUNT_W) ? WW : COUNT_W;

  ctrl_t ctrl;
  stat_t stat;

  logic [NW-1:0]      n_r, n_nxt;
  logic [WW-1:0]      k_r, k_nxt;
  logic [WW-1:0]      base_r, base_nxt;
  logic [WW-1:0]      sq_r, sq_nxt;
  logic [WW-1:0]      stride_r, stride_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               rv_r, rv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               we, wdata, re, rdata;
  logic [AW-1:0]      waddr, raddr;
  logic [CW-1:0]      limit_ext;
  logic [WW-1:0]      n_ext;

  assign limit_ext = CW'(in_req.limit);
  assign n_ext     = WW'(n_r);

  assign stat.in_valid  = in_req.valid;
  assign stat.k_ge_n    = (k_r >= n_ext);
  assign stat.sq_ge_n   = (sq_r >= n_ext);
  assign stat.composite = rdata;
  assign stat.out_free  = !out_valid_r || out_res.ready;

  psc_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  psc_bitmap #(
    .DEPTH (MAX_BOUND),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    sq_nxt        = sq_r;
    stride_nxt    = stride_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = 1'b0;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_count_nxt = out_count_r;
    we            = 1'b0;
    wdata         = 1'b0;
    waddr         = k_r[AW-1:0];
    re            = 1'b0;
    raddr         = k_r[AW-1:0];

    // tally the read issued last cycle
    if (rv_r && !rdata && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    if (ctrl.load) begin
      n_nxt = (limit_ext > CW'(MAX_BOUND)) ? NW'(MAX_BOUND) : NW'(limit_ext);
      k_nxt = '0;
    end
    if (ctrl.fill) begin
      // even numbers from 4 start composite, all others start unmarked
      we    = 1'b1;
      wdata = (k_r[WW-1:2] != '0) && !k_r[0];
      k_nxt = k_r + 1'b1;
    end
    if (ctrl.sinit) begin
      base_nxt   = WW'(3);
      sq_nxt     = WW'(9);
      stride_nxt = WW'(6);
    end
    if (ctrl.sread) begin
      re    = 1'b1;
      raddr = base_r[AW-1:0];
    end
    if (ctrl.sload) begin
      k_nxt = sq_r;
    end
    if (ctrl.strike) begin
      we    = 1'b1;
      wdata = 1'b1;
      k_nxt = k_r + stride_r;
    end
    if (ctrl.snext) begin
      // (i+2)^2 = i^2 + 4i + 4
      base_nxt   = base_r + WW'(2);
      sq_nxt     = sq_r + (base_r << 2) + WW'(4);
      stride_nxt = stride_r + WW'(4);
    end
    if (ctrl.cinit) begin
      k_nxt   = WW'(2);
      cnt_nxt = '0;
    end
    if (ctrl.cread) begin
      re     = 1'b1;
      rv_nxt = 1'b1;
      k_nxt  = k_r + 1'b1;
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    base_r      <= base_nxt;
    sq_r        <= sq_nxt;
    stride_r    <= stride_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_req.ready        = ctrl.in_ready;
  assign out_res.valid       = out_valid_r;
  assign out_res.prime_count = out_count_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while a run was in progress");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (k_r < n_ext))
    else $error("bitmap write beyond the bound");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (MW'(cnt_r) <= MW'(n_r)))
    else $error("prime count exceeds the bound");

  a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re))
    else $error("bitmap read and write in one cycle");

endmodule

### design/psc_bitmap.sv
`timescale 1ns / 1ps
module psc_bitmap #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/psc_useq.sv
`timescale 1ns / 1ps
module psc_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  psc_pkg::stat_t stat,
  output psc_pkg::ctrl_t ctrl
);
  import psc_pkg::*;

  step_t  step_r, step_nxt;
  uword_t word;
  logic   cond_val;
  logic   fire;

  assign word = ucode_rom(step_r);

  always_comb begin
    case (word.cond)
      COND_ALWAYS:    cond_val = 1'b1;
      COND_IN_VALID:  cond_val = stat.in_valid;
      COND_K_GE_N:    cond_val = stat.k_ge_n;
      COND_SQ_GE_N:   cond_val = stat.sq_ge_n;
      COND_COMPOSITE: cond_val = stat.composite;
      COND_OUT_FREE:  cond_val = stat.out_free;
      default:        cond_val = 1'b1;
    endcase
  end

  assign fire     = (cond_val == word.on_true);
  assign step_nxt = cond_val ? word.tgt_t : word.tgt_f;

  always_comb begin
    ctrl          = '0;
    ctrl.in_ready = (word.act == ACT_LOAD);
    unique case (word.act)
      ACT_LOAD:   ctrl.load   = fire;
      ACT_FILL:   ctrl.fill   = fire;
      ACT_SINIT:  ctrl.sinit  = fire;
      ACT_SREAD:  ctrl.sread  = fire;
      ACT_SLOAD:  ctrl.sload  = fire;
      ACT_STRIKE: ctrl.strike = fire;
      ACT_SNEXT:  ctrl.snext  = fire;
      ACT_CINIT:  ctrl.cinit  = fire;
      ACT_CREAD:  ctrl.cread  = fire;
      ACT_EMIT:   ctrl.emit   = fire;
      default:    ctrl.load   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
